// ===== design/spq_pkg.sv =====
package spq_pkg;

  // operation codes carried by func
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;

  // one stored entry of the sorted list
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } entry_t;

  // command broadcast to every cell in the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } cmd_t;

endpackage

// ===== design/spq_cell.sv =====
module spq_cell (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left_entry,
  input  logic           left_keep,
  input  spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t entry,
  output spq_pkg::entry_t entry_next,
  output logic           keep
);

  // entry stays put on insert when it sorts at or before the new word
  assign keep = entry.valid && ($signed(entry.prio) <= $signed(cmd.prio));

  // next content: hold, take the new word, shift in from left or right
  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      if (!keep) begin
        if (left_keep) begin
          entry_next.valid = 1'b1;
          entry_next.value = cmd.value;
          entry_next.prio  = cmd.prio;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (cmd.rem) begin
      entry_next = right_entry;
    end
  end

  // valid bit cleared on reset, payload left alone
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.value <= entry_next.value;
    entry.prio  <= entry_next.prio;
  end

endmodule

// ===== design/stable_priority_queue.sv =====
// the result of an accepted word is registered in the output register
// one word per cycle unless stalled; every cell compares and shifts in parallel
// the output register frees when its result is taken or in the same cycle
// reset (rst, synchronous): queue empty, all cell valid bits clear, no result held
module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic signed [31:0] value,
  input  logic signed [31:0] priority_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic signed [31:0] removed_value,
  output logic signed [31:0] removed_priority,
  output logic signed [31:0] head_value,
  output logic signed [31:0] head_priority,
  output logic [4:0]  entry_count,
  output logic        is_empty
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::entry_t cells      [DEPTH];
  spq_pkg::entry_t cells_next [DEPTH];
  logic            keeps      [DEPTH];
  spq_pkg::cmd_t   cmd;
  spq_pkg::entry_t empty_entry;

  logic [CW-1:0] held_count;
  logic [CW-1:0] held_count_next;
  logic [CW+spq_pkg::COUNT_W-1:0] count_ext;
  logic          accept;
  logic          full;
  logic          empty;
  logic [1:0]    status_next;

  assign empty_entry = '0;

  // handshake: accept whenever the output register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign full  = cells[DEPTH-1].valid;
  assign empty = !cells[0].valid;

  // command to the cell chain
  always_comb begin
    cmd.ins   = accept && (func == spq_pkg::FUNC_INSERT) && !full;
    cmd.rem   = accept && (func == spq_pkg::FUNC_REMOVE) && !empty;
    cmd.value = value;
    cmd.prio  = priority_req;
  end

  // chain of cells, slot 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_keep;
    if (i == 0) begin : g_first
      assign left_entry = empty_entry;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_entry = cells[i-1];
      assign left_keep  = keeps[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = empty_entry;
    end else begin : g_inner
      assign right_entry = cells[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (cells[i]),
      .entry_next  (cells_next[i]),
      .keep        (keeps[i])
    );
  end

  // count update and status
  always_comb begin
    held_count_next = held_count;
    if (cmd.ins) begin
      held_count_next = held_count + CW'(1);
    end else if (cmd.rem) begin
      held_count_next = held_count - CW'(1);
    end
    status_next = spq_pkg::ST_OK;
    if (func == spq_pkg::FUNC_INSERT) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      status_next = spq_pkg::ST_EMPTY;
    end
  end

  assign count_ext = {{spq_pkg::COUNT_W{1'b0}}, held_count_next};

  // count register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      status           <= status_next;
      removed_value    <= cmd.rem ? cells[0].value : '0;
      removed_priority <= cmd.rem ? cells[0].prio : '0;
      head_value       <= cells_next[0].valid ? cells_next[0].value : '0;
      head_priority    <= cells_next[0].valid ? cells_next[0].prio : '0;
      entry_count      <= count_ext[spq_pkg::COUNT_W-1:0];
      is_empty         <= !cells_next[0].valid;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int QDEPTH     = 16;
  localparam int RAND_WORDS = 1650;
  localparam int MAX_SHOWN  = 10;

  // one result word, laid out in port order
  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] rem_v;
    logic [31:0] rem_p;
    logic [31:0] head_v;
    logic [31:0] head_p;
    logic [4:0]  cnt;
    logic        empty;
  } result_t;

  // one directed stimulus row; typed rows carry their result written out
  typedef struct packed {
    logic        typed;
    logic        fn;
    logic [31:0] v;
    logic [31:0] p;
    result_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = spq_pkg::FUNC_INSERT;
  logic signed [31:0] value = '0;
  logic signed [31:0] priority_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [31:0] removed_value;
  logic signed [31:0] removed_priority;
  logic signed [31:0] head_value;
  logic signed [31:0] head_priority;
  logic [4:0] entry_count;
  logic is_empty;

  stable_priority_queue #(.DEPTH(QDEPTH)) DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .value            (value),
    .priority_req     (priority_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .removed_value    (removed_value),
    .removed_priority (removed_priority),
    .head_value       (head_value),
    .head_priority    (head_priority),
    .entry_count      (entry_count),
    .is_empty         (is_empty)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // sorted list mirror of the queue
  logic signed [31:0] sorted_val [QDEPTH];
  logic signed [31:0] sorted_pri [QDEPTH];
  int sorted_n = 0;
  int n_ins = 0, n_rem = 0, n_full = 0, n_empty = 0;

  result_t pending_results[$];
  int err_count = 0;
  int burst_left = 0;

  // apply one word to the mirror and return the result it should produce
  function automatic result_t queue_step(input logic fn, input logic signed [31:0] v,
                                         input logic signed [31:0] p);
    result_t r;
    int pos;
    int i;
    r = '0;
    r.st = spq_pkg::ST_OK;
    if (fn == spq_pkg::FUNC_INSERT) begin
      if (sorted_n >= QDEPTH) begin
        r.st = spq_pkg::ST_FULL;
        n_full++;
      end else begin
        // new entry goes behind every entry of lower or equal priority
        pos = 0;
        while (pos < sorted_n && sorted_pri[pos] <= p) pos++;
        for (i = sorted_n; i > pos; i--) begin
          sorted_val[i] = sorted_val[i-1];
          sorted_pri[i] = sorted_pri[i-1];
        end
        sorted_val[pos] = v;
        sorted_pri[pos] = p;
        sorted_n++;
        n_ins++;
      end
    end else begin
      if (sorted_n == 0) begin
        r.st = spq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        r.rem_v = sorted_val[0];
        r.rem_p = sorted_pri[0];
        for (i = 0; i + 1 < sorted_n; i++) begin
          sorted_val[i] = sorted_val[i+1];
          sorted_pri[i] = sorted_pri[i+1];
        end
        sorted_n--;
        n_rem++;
      end
    end
    if (sorted_n > 0) begin
      r.head_v = sorted_val[0];
      r.head_p = sorted_pri[0];
    end
    r.cnt = 5'(sorted_n);
    r.empty = (sorted_n == 0);
    return r;
  endfunction

  // send one word in bursts with random gaps, then log what it should return
  task automatic send_word(input logic fn, input logic [31:0] v, input logic [31:0] p,
                           input logic typed, input result_t want);
    int gap;
    result_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= fn;
    value <= v;
    priority_req <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = queue_step(fn, v, p);
    pending_results.push_back(typed ? want : r);
  endtask

  // receiver stall pattern: always ready, coin flip, or ready with long stalls
  int rx_mode = 0;
  int rx_cycles = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rx_cycles % 150 == 0) rx_mode = $urandom_range(2);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(3) == 0) stall_left = $urandom_range(12, 1);
        end
      end
    endcase
    rx_cycles++;
  end

  // result checker
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {status, removed_value, removed_priority, head_value, head_priority,
             entry_count, is_empty};
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("unexpected result word: st=%0d rv=%h rp=%h hv=%h hp=%h n=%0d e=%0b",
                   got.st, got.rem_v, got.rem_p, got.head_v, got.head_p, got.cnt, got.empty);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_SHOWN) begin
            $display("mismatch exp: st=%0d rv=%h rp=%h hv=%h hp=%h n=%0d e=%0b",
                     want.st, want.rem_v, want.rem_p, want.head_v, want.head_p,
                     want.cnt, want.empty);
            $display("         got: st=%0d rv=%h rp=%h hv=%h hp=%h n=%0d e=%0b",
                     got.st, got.rem_v, got.rem_p, got.head_v, got.head_p,
                     got.cnt, got.empty);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    int k;
    int ins_pct;
    logic fn;
    logic [31:0] v;
    logic [31:0] p;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // remove on empty queue right after reset
    rows.push_back('{1'b1, spq_pkg::FUNC_REMOVE, 32'h0, 32'h0,
                     '{spq_pkg::ST_EMPTY, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1}});
    // first insert at the top of both ranges becomes the head
    rows.push_back('{1'b1, spq_pkg::FUNC_INSERT, 32'h7fffffff, 32'h7fffffff,
                     '{spq_pkg::ST_OK, 32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff,
                       5'd1, 1'b0}});
    // most negative priority jumps to the head
    rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'h80000000, 32'h80000000, '0});
    // equal priorities must leave in arrival order
    rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'hffffffff, 32'h0, '0});
    rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'h1, 32'h0, '0});
    rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'h2, 32'h0, '0});
    // removes carry junk in the ignored fields
    rows.push_back('{1'b0, spq_pkg::FUNC_REMOVE, 32'haaaaaaaa, 32'h55555555, '0});
    rows.push_back('{1'b0, spq_pkg::FUNC_REMOVE, 32'h55555555, 32'haaaaaaaa, '0});
    rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'h0, 32'hffffffff, '0});
    // fill to capacity behind the max-priority entry
    for (k = 0; k < 12; k++)
      rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'(100 + k), 32'h7fffffff, '0});
    // insert on full queue is refused even with the best priority
    rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'h5a5a5a5a, 32'h80000000, '0});
    rows.push_back('{1'b0, spq_pkg::FUNC_REMOVE, 32'h0, 32'h0, '0});
    rows.push_back('{1'b0, spq_pkg::FUNC_INSERT, 32'h12345678, 32'h7ffffffe, '0});

    foreach (rows[i])
      send_word(rows[i].fn, rows[i].v, rows[i].p, rows[i].typed, rows[i].want);

    // random words; insert bias shifts so the queue swings between empty and full
    ins_pct = 50;
    for (k = 0; k < RAND_WORDS; k++) begin
      if (k % 60 == 0) begin
        case ($urandom_range(2))
          0: ins_pct = 20;
          1: ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      fn = ($urandom_range(99) < ins_pct) ? spq_pkg::FUNC_INSERT : spq_pkg::FUNC_REMOVE;
      v = $urandom;
      case ($urandom_range(3))
        0: p = 32'($urandom_range(6)) - 32'd3;
        1: p = $urandom;
        2: begin
          case ($urandom_range(3))
            0: p = 32'h80000000;
            1: p = 32'h7fffffff;
            2: p = 32'h0;
            default: p = 32'hffffffff;
          endcase
        end
        default: p = 32'($urandom_range(15));
      endcase
      send_word(fn, v, p, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain outstanding results
    k = 0;
    while (pending_results.size() > 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_count += pending_results.size();
      $display("%0d result words never arrived", pending_results.size());
    end

    $display("covered %0d words: %0d inserts, %0d removes, %0d refused full, %0d refused empty",
             n_ins + n_rem + n_full + n_empty, n_ins, n_rem, n_full, n_empty);
    $display("failures: %0d", err_count);
    if (err_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
